// ----- rtl/core/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16 decoder: field widths, register map,
// stop codes and the lead-byte decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int BYTE_W       = 8;
    localparam int UNIT_W       = 16;
    localparam int LIMIT_W      = 24;
    localparam int UCOUNT_W     = 24;
    localparam int COUNT_W_DEF  = 24;
    localparam int SEQ_W        = 3;
    localparam int SEEN_W       = 2;
    localparam int CONT_BITS    = 6;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // Output tdata: code_unit, unit_count. Output tuser: unit_valid, stop_reason.
    localparam int M_TDATA_W    = UNIT_W + UCOUNT_W;
    localparam int M_TUSER_W    = 1 + 2;

    typedef enum logic [1:0] {
        STOP_END_INPUT = 2'd0,
        STOP_INVALID   = 2'd1,
        STOP_TRUNCATED = 2'd2,
        STOP_LIMIT     = 2'd3
    } t_stop_reason;

    // Register select is paddr[2]; the low address bits are the byte offset.
    typedef enum logic {
        REG_COUNT_ONLY = 1'b0,
        REG_UNIT_LIMIT = 1'b1
    } t_reg_sel;

    // Sequence length announced by a lead byte; 0 means an invalid lead.
    function automatic logic [SEQ_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [SEQ_W-1:0] len;
        len = '0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Payload bits that a multi-byte lead contributes to the code point.
    function automatic logic [UNIT_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                    input logic [SEQ_W-1:0] len);
        logic [UNIT_W-1:0] bits;
        case (len)
            3'd2:    bits = UNIT_W'(b[4:0]);
            3'd3:    bits = UNIT_W'(b[3:0]);
            3'd4:    bits = UNIT_W'(b[2:0]);
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 decoder top level: stream in, stream out, APB registers.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

// One UTF-8 byte is accepted per clock whenever the sink keeps up: each
// beat updates the running sequence state and, when it produces a result,
// loads the output register. s_tready stays high while the output
// register is empty or being drained in the same cycle; a stalled sink
// holds one result and stops the input after that. A result is on the
// master side in the cycle after its input beat. Outside count mode
// (count_only clear, nonzero limit) each completed character gives one
// 16-bit unit (four-byte sequences keep the low 16 bits); the final
// result of a string has tlast set and carries the count and the stop
// reason. Configuration must be written while idle.
module utf8_to_utf16_decoder #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_W_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream. tdata: data_byte[7:0]. tlast: last_byte.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8u16_pkg::BYTE_W-1:0]       s_tdata,
    input  logic                               s_tlast,
    // Output stream. tdata: code_unit[15:0], unit_count[39:16].
    // tuser: unit_valid[0], stop_reason[2:1]. tlast: done_res.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u8u16_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [u8u16_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                               m_tlast,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [u8u16_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [u8u16_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [u8u16_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import u8u16_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration registers.
    logic               r_count_only;
    logic [LIMIT_W-1:0] r_unit_limit;

    // String state.
    logic [SEQ_W-1:0]       r_seq_len,   n_seq_len;
    logic [SEEN_W-1:0]      r_seen,      n_seen;
    logic [UNIT_W-1:0]      r_partial,   n_partial;
    logic [COUNT_WIDTH-1:0] r_char_count, n_char_count;
    logic                   r_stopped,   n_stopped;

    // Output register.
    logic                   r_out_valid;
    logic [UNIT_W-1:0]      r_out_unit;
    logic                   r_out_uvalid;
    logic [UCOUNT_W-1:0]    r_out_count;
    logic                   r_out_done;
    t_stop_reason           r_out_reason;

    logic                   in_beat;
    logic                   cnt_mode;
    logic                   res_emit;
    logic [UNIT_W-1:0]      res_unit;
    logic                   res_valid;
    logic                   res_done;
    t_stop_reason           res_reason;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   cfg_wr;

    // ---------------- Configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_only <= 1'b0;
            r_unit_limit <= '0;
        end else if (cfg_wr) begin
            case (t_reg_sel'(paddr[2]))
                REG_COUNT_ONLY: r_count_only <= pwdata[0];
                REG_UNIT_LIMIT: r_unit_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_sel'(paddr[2]))
            REG_COUNT_ONLY: prdata = APB_DATA_W'(r_count_only);
            REG_UNIT_LIMIT: prdata = APB_DATA_W'(r_unit_limit);
            default:        prdata = '0;
        endcase
    end

    // ---------------- Per-byte decode ----------------
    assign s_tready = !r_out_valid || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign cnt_mode = r_count_only || (r_unit_limit == '0);

    always_comb begin
        logic [SEQ_W-1:0]       len;
        logic [COUNT_WIDTH-1:0] bumped;
        logic                   at_limit;

        len      = lead_length(s_tdata);
        bumped   = (r_char_count != COUNT_MAX) ? r_char_count + 1'b1 : r_char_count;
        at_limit = CMP_W'(r_char_count) >= CMP_W'(r_unit_limit);

        n_seq_len    = r_seq_len;
        n_seen       = r_seen;
        n_partial    = r_partial;
        n_char_count = r_char_count;
        n_stopped    = r_stopped;
        res_unit     = '0;
        res_valid    = 1'b0;
        res_done     = 1'b0;
        res_reason   = STOP_END_INPUT;
        res_emit     = 1'b0;
        res_count    = r_char_count;

        if (r_stopped) begin
            // Drop bytes until the end of the string.
            if (s_tlast) begin
                n_seq_len    = '0;
                n_seen       = '0;
                n_partial    = '0;
                n_char_count = '0;
                n_stopped    = 1'b0;
            end
        end else begin
            if (r_seq_len != '0) begin
                n_partial = {r_partial[UNIT_W-CONT_BITS-1:0], s_tdata[CONT_BITS-1:0]};
                n_seen    = r_seen + 1'b1;
                if (SEQ_W'(n_seen) == r_seq_len || n_seen == '0) begin
                    n_seq_len = '0;
                    n_seen    = '0;
                    if (!cnt_mode) begin
                        res_unit     = n_partial;
                        res_valid    = 1'b1;
                        n_char_count = bumped;
                    end
                    n_partial = '0;
                end
            end else if (len == '0) begin
                res_done   = 1'b1;
                res_reason = STOP_INVALID;
            end else if (!cnt_mode && at_limit) begin
                // Limit already reached or lowered below the count.
                res_done   = 1'b1;
                res_reason = STOP_LIMIT;
            end else if (cnt_mode) begin
                n_char_count = bumped;
                if (len > SEQ_W'(1)) begin
                    n_seq_len = len;
                    n_seen    = SEEN_W'(1);
                    n_partial = '0;
                end
            end else if (len == SEQ_W'(1)) begin
                res_unit     = UNIT_W'(s_tdata);
                res_valid    = 1'b1;
                n_char_count = bumped;
            end else begin
                n_seq_len = len;
                n_seen    = SEEN_W'(1);
                n_partial = lead_bits(s_tdata, len);
            end

            if (!res_done) begin
                if (s_tlast) begin
                    res_done   = 1'b1;
                    res_reason = (!cnt_mode && n_seq_len != '0) ? STOP_TRUNCATED
                                                                : STOP_END_INPUT;
                end else if (!cnt_mode && res_valid &&
                             CMP_W'(n_char_count) >= CMP_W'(r_unit_limit)) begin
                    res_done   = 1'b1;
                    res_reason = STOP_LIMIT;
                end
            end

            res_emit  = res_valid || res_done;
            // The reported count includes this byte but precedes the end-of-string clear.
            res_count = n_char_count;

            if (res_done) begin
                n_seq_len = '0;
                n_seen    = '0;
                n_partial = '0;
                if (s_tlast) begin
                    n_char_count = '0;
                    n_stopped    = 1'b0;
                end else begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len    <= '0;
            r_seen       <= '0;
            r_partial    <= '0;
            r_char_count <= '0;
            r_stopped    <= 1'b0;
        end else if (in_beat) begin
            r_seq_len    <= n_seq_len;
            r_seen       <= n_seen;
            r_partial    <= n_partial;
            r_char_count <= n_char_count;
            r_stopped    <= n_stopped;
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat && res_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && res_emit) begin
            r_out_unit   <= res_unit;
            r_out_uvalid <= res_valid;
            r_out_count  <= UCOUNT_W'(res_count);
            r_out_done   <= res_done;
            r_out_reason <= res_reason;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_count, r_out_unit};
    assign m_tuser  = {r_out_reason, r_out_uvalid};
    assign m_tlast  = r_out_done;

    // ---------------- Assertions ----------------
    a_seq_seen_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_len == '0) == (r_seen == '0))
        else $error("sequence length and bytes seen disagree");

    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_seq_len == '0 && r_partial == '0))
        else $error("sequence state left over after a stop");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && s_tlast) |=> (r_char_count == '0 && !r_stopped && r_seq_len == '0))
        else $error("string state not cleared after last byte");

    a_nounit_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("result with neither unit nor done");

    a_reason_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == STOP_END_INPUT))
        else $error("stop reason set on a non-final result");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for utf8_to_utf16_decoder: drives UTF-8 strings into the byte
// stream, predicts every code unit and done beat, and checks them on the output stream.
// Depends on u8u16_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
    import u8u16_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int SETTLE      = 4;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BYTES = 100;
    localparam int CNT_W       = 24;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    // One result beat, fields in the order they are compared.
    typedef struct packed {
        logic [UNIT_W-1:0]   code_unit;
        logic                unit_valid;
        logic [UCOUNT_W-1:0] unit_count;
        logic                done_res;
        t_stop_reason        reason;
    } unit_beat_t;

    // Behavioral copy of the decoder: string state, registers and the beats still owed.
    class utf8_string_model;
        bit                count_only;
        bit [LIMIT_W-1:0]  unit_limit;
        bit [SEQ_W-1:0]    seq_len;
        bit [SEEN_W-1:0]   seen;
        bit [UNIT_W-1:0]   partial;
        bit [CNT_W-1:0]    chars;
        bit                stopped;
        unit_beat_t        pending_beats[$];
        int                mismatches;
        int                beats_checked;
        int                stops[4];

        function void clear_string();
            seq_len = '0;
            seen    = '0;
            partial = '0;
            chars   = '0;
            stopped = 1'b0;
        endfunction

        function void set_reg(t_reg_sel sel, logic [APB_DATA_W-1:0] value);
            if (sel == REG_COUNT_ONLY) begin
                count_only = value[0];
            end else begin
                unit_limit = value[LIMIT_W-1:0];
            end
        endfunction

        function void bump();
            if (chars != '1) chars++;
        endfunction

        function bit [SEQ_W-1:0] seq_length_of(bit [BYTE_W-1:0] b);
            casez (b)
                8'b0???????: return 3'd1;
                8'b110?????: return 3'd2;
                8'b1110????: return 3'd3;
                8'b11110???: return 3'd4;
                default:     return 3'd0;
            endcase
        endfunction

        function void take_byte(bit [BYTE_W-1:0] b, bit last);
            bit             cnt_mode;
            bit             valid;
            bit             done;
            bit [SEQ_W-1:0] len;
            unit_beat_t     beat;
            cnt_mode = count_only || (unit_limit == 0);
            valid    = 1'b0;
            done     = 1'b0;
            beat     = '0;
            if (stopped) begin
                if (last) clear_string();
                return;
            end
            if (seq_len != 0) begin
                partial = {partial[UNIT_W-7:0], b[5:0]};
                seen    = seen + 1'b1;
                // A four-byte sequence wraps the 2-bit byte counter back to zero.
                if (seen == 0 || {1'b0, seen} == seq_len) begin
                    seq_len = '0;
                    seen    = '0;
                    if (!cnt_mode) begin
                        beat.code_unit = partial;
                        valid = 1'b1;
                        bump();
                    end
                    partial = '0;
                end
            end else begin
                len = seq_length_of(b);
                if (len == 0) begin
                    done = 1'b1;
                    beat.reason = STOP_INVALID;
                end else if (!cnt_mode && chars >= unit_limit) begin
                    done = 1'b1;
                    beat.reason = STOP_LIMIT;
                end else if (cnt_mode) begin
                    bump();
                    if (len > 1) begin
                        seq_len = len;
                        seen    = 2'd1;
                        partial = '0;
                    end
                end else if (len == 1) begin
                    beat.code_unit = {8'h00, b};
                    valid = 1'b1;
                    bump();
                end else begin
                    seq_len = len;
                    seen    = 2'd1;
                    partial = {8'h00, b & (8'h7f >> len)};
                end
            end
            if (!done) begin
                if (last) begin
                    done = 1'b1;
                    beat.reason = (!cnt_mode && seq_len != 0) ? STOP_TRUNCATED
                                                              : STOP_END_INPUT;
                end else if (!cnt_mode && valid && chars >= unit_limit) begin
                    done = 1'b1;
                    beat.reason = STOP_LIMIT;
                end
            end
            if (!valid && !done) return;
            beat.unit_valid = valid;
            beat.unit_count = chars;
            beat.done_res   = done;
            pending_beats.push_back(beat);
            if (done) begin
                if (last) begin
                    clear_string();
                end else begin
                    stopped = 1'b1;
                    seq_len = '0;
                    seen    = '0;
                    partial = '0;
                end
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_beat(unit_beat_t got);
            unit_beat_t want;
            if (pending_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual 0x%0h", $time, got);
                mismatches++;
                return;
            end
            want = pending_beats.pop_front();
            beats_checked++;
            if (want.done_res) stops[want.reason]++;
            if (got.code_unit !== want.code_unit)
                report("code_unit", want.code_unit, got.code_unit);
            if (got.unit_valid !== want.unit_valid)
                report("unit_valid", want.unit_valid, got.unit_valid);
            if (got.unit_count !== want.unit_count)
                report("unit_count", want.unit_count, got.unit_count);
            if (got.done_res !== want.done_res)
                report("done_res", want.done_res, got.done_res);
            if (got.reason !== want.reason)
                report("stop_reason", want.reason, got.reason);
        endfunction
    endclass

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    utf8_string_model units = new();
    int  bytes_sent;
    int  strings_sent;
    int  stall_reqs;
    int  stall_served;
    int  hold_left;
    bit  quiet;

    utf8_to_utf16_decoder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Both streams are sampled here with their pre-edge values. An output beat always
    // belongs to an earlier input beat, so it is checked before the new byte is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                units.check_beat(unit_beat_t'({m_tdata[UNIT_W-1:0], m_tuser[0],
                                               m_tdata[M_TDATA_W-1:UNIT_W], m_tlast,
                                               m_tuser[2:1]}));
            if (s_tvalid && s_tready) units.take_byte(s_tdata, s_tlast);
        end
    end

    // Sink side: random back-pressure, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_left == 0 && stall_served != stall_reqs) begin
            stall_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 30);
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d result beats outstanding.", units.pending_beats.size());
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        // Each idle cycle is drawn on its own, with a 30 percent chance per draw.
        while (!quiet && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_str(input logic [BYTE_W-1:0] s[$], input logic end_str);
        foreach (s[i]) send_byte(s[i], end_str && (i == s.size() - 1));
    endtask

    // Stops the sender and waits until every owed beat has come out; a byte that gives
    // no result may still be in the pipe, hence the extra cycles.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (units.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_sel sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        units.set_reg(sel, value);
    endtask

    task automatic set_mode(input logic count_only, input logic [LIMIT_W-1:0] limit);
        drain();
        write_reg(REG_COUNT_ONLY, {31'd0, count_only});
        write_reg(REG_UNIT_LIMIT, {8'd0, limit});
    endtask

    function automatic logic [BYTE_W-1:0] random_lead(int len);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom_range(255));
        case (len)
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // Continuation bytes are not checked by the block, so a few are arbitrary bytes.
    function automatic logic [BYTE_W-1:0] cont_byte();
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom_range(255));
        return ($urandom_range(99) < 10) ? r : {2'b10, r[5:0]};
    endfunction

    // Mostly well-formed characters; some noise bytes and some strings cut off mid-sequence.
    task automatic send_random_string();
        logic [BYTE_W-1:0] s[$];
        int n_chars;
        int pick;
        int len;
        n_chars = $urandom_range(1, 12);
        for (int c = 0; c < n_chars; c++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                s.push_back(BYTE_W'($urandom_range(255)));
            end else if (pick < 50) begin
                s.push_back(BYTE_W'($urandom_range(127)));
            end else begin
                len = $urandom_range(2, 4);
                s.push_back(random_lead(len));
                repeat (len - 1) s.push_back(cont_byte());
            end
        end
        if ($urandom_range(99) < 12) begin
            len = $urandom_range(2, 4);
            s.push_back(random_lead(len));
            repeat ($urandom_range(0, len - 2)) s.push_back(cont_byte());
        end
        send_str(s, 1'b1);
        strings_sent++;
    endtask

    initial begin
        int phase_start;
        bit paused;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every sequence length, the ASCII extremes, then the early-stop cases.
        set_mode(1'b0, 24'd100);
        send_str({8'h00, 8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                  8'hf0, 8'h9f, 8'h98, 8'h80, 8'h41}, 1'b1);
        send_str({8'h80, 8'h41}, 1'b1);
        send_str({8'hf8}, 1'b1);
        send_str({8'he2, 8'h82}, 1'b1);
        // Limit hit before the last byte, then exactly on it.
        set_mode(1'b0, 24'd1);
        send_str({8'h41, 8'h42}, 1'b1);
        send_str({8'h41}, 1'b1);
        // Count-only mode still counts a cut-off final character.
        set_mode(1'b1, 24'd1);
        send_str({8'he2, 8'h82}, 1'b1);
        // Lead counted in count mode, sequence finished after switching to convert mode.
        send_str({8'hc3}, 1'b0);
        set_mode(1'b0, 24'd100);
        send_str({8'ha9, 8'h41}, 1'b1);
        // Limit lowered below the running count in the middle of a string.
        send_str({8'h41, 8'h42}, 1'b0);
        set_mode(1'b0, 24'd1);
        send_str({8'h43, 8'h44}, 1'b1);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_mode(1'b0, LIMIT_MAX);
                1: set_mode(1'b0, LIMIT_W'($urandom_range(1, 6)));
                2: set_mode(1'b1, LIMIT_W'($urandom_range(0, 16777215)));
                3: set_mode(1'b0, '0);
                4: set_mode(1'b0, LIMIT_W'($urandom_range(7, 40)));
                default: set_mode(1'b0, 24'd1);
            endcase
            // The sink holds off while the source keeps offering, so the input backs up.
            if (p == 0) stall_reqs++;
            quiet = (p == 4);
            phase_start = bytes_sent;
            paused = 1'b0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_random_string();
                if (p == 0 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            quiet = 1'b0;
        end

        drain();
        $display("Sent %0d bytes in %0d random strings plus directed cases; %0d beats checked.",
                 bytes_sent, strings_sent, units.beats_checked);
        $display("Strings ended by input end %0d, bad lead %0d, cut-off %0d, limit %0d.",
                 units.stops[STOP_END_INPUT], units.stops[STOP_INVALID],
                 units.stops[STOP_TRUNCATED], units.stops[STOP_LIMIT]);
        if (units.mismatches == 0 && units.pending_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
